// File: hdl/legv8_pkg.sv
// ----------------------------------------------------------------------------
// legv8_pkg
// Opcodes, flag type and fixed sizes shared by the execute unit.
// ----------------------------------------------------------------------------
package legv8_pkg;

  localparam int NUM_REGS      = 32;
  localparam int REG_AW        = $clog2(NUM_REGS);
  localparam int XLEN          = 64;
  localparam int PROGRAM_LINES = 1024;
  localparam int LINE_W        = $clog2(PROGRAM_LINES);

  localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(30);

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADDS  = 5'd1,
    OP_ADDI  = 5'd2,
    OP_ADDIS = 5'd3,
    OP_SUB   = 5'd4,
    OP_SUBS  = 5'd5,
    OP_SUBI  = 5'd6,
    OP_SUBIS = 5'd7,
    OP_AND   = 5'd8,
    OP_ANDS  = 5'd9,
    OP_ORR   = 5'd10,
    OP_EOR   = 5'd11,
    OP_ANDI  = 5'd12,
    OP_ANDIS = 5'd13,
    OP_ORRI  = 5'd14,
    OP_EORI  = 5'd15,
    OP_LSL   = 5'd16,
    OP_LSR   = 5'd17,
    OP_B     = 5'd18,
    OP_BL    = 5'd19,
    OP_BR    = 5'd20,
    OP_CBZ   = 5'd21,
    OP_CBNZ  = 5'd22
  } op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

endpackage

// File: hdl/legv8_ram.sv
// ----------------------------------------------------------------------------
// legv8_ram
// Generic RAM: one write port, two read ports, registered read with enable.
// A read in the same cycle as a write to that entry returns the old data.
// ----------------------------------------------------------------------------
module legv8_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: hdl/legv8_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// legv8_subset_execute_unit
// Executes decoded LEGv8 instructions against a 32 x 64 register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per
//   transaction; output channel (out_valid/out_ready) returns one result per
//   instruction: next line, write indication, written value and NZCV.
//   An instruction passes the execute stage register, then the output
//   register, where out_valid rises. Throughput is one instruction per
//   cycle while the output is not stalled: the register file RAM is read
//   when the instruction is taken, written in the execute stage, with a
//   bypass of the last write covering back-to-back dependencies.
//   The second read port serves the tested register for BR/CBZ/CBNZ.
//   Reset clears the line counter, the flags and a valid bit per register,
//   so every register reads as zero until written; no clearing pass.
//   When the receiver stalls, the result holds in the output register, one
//   more instruction waits in the execute stage, and in_ready then drops.
// ----------------------------------------------------------------------------
module legv8_subset_execute_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         action,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         first_reg,
  input  logic [4:0]         second_reg,
  input  logic [11:0]        immediate,
  input  logic [9:0]         target_line,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         next_line,
  output logic               wrote,
  output logic signed [63:0] written_value,
  output logic               flag_n,
  output logic               flag_z,
  output logic               flag_c,
  output logic               flag_v
);
  import legv8_pkg::*;

  logic                in_fire;
  logic                s1_valid;
  logic                s1_fire;
  op_t                 s1_action;
  logic [REG_AW-1:0]   s1_dest;
  logic [REG_AW-1:0]   s1_addr_a;
  logic [REG_AW-1:0]   s1_addr_b;
  logic [11:0]         s1_imm;
  logic [LINE_W-1:0]   s1_target;

  logic [NUM_REGS-1:0] reg_valid;
  logic                wb_en;
  logic [REG_AW-1:0]   wb_addr;
  logic [XLEN-1:0]     wb_data;

  logic [XLEN-1:0]     ram_a;
  logic [XLEN-1:0]     ram_b;
  logic [REG_AW-1:0]   rd_addr_b;

  logic [LINE_W-1:0]   line;
  flags_t              flags;
  flags_t              out_flags;

  logic [XLEN-1:0]     a_val;
  logic [XLEN-1:0]     b_val;
  logic [XLEN-1:0]     imm64;
  logic [XLEN-1:0]     opnd;
  logic [XLEN-1:0]     bop;
  logic [XLEN:0]       sum;
  logic [XLEN-1:0]     arith;
  logic                carry;
  logic                ovf;
  logic                uses_imm;
  logic                is_sub;
  logic [LINE_W-1:0]   seq_line;
  logic [LINE_W-1:0]   line_next;
  logic                do_write;
  logic [REG_AW-1:0]   wr_addr;
  logic [XLEN-1:0]     wr_value;
  flags_t              flags_next;
  logic                redirect;

  assign in_fire   = in_valid && in_ready;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign rd_addr_b = (action == OP_BR || action == OP_CBZ || action == OP_CBNZ) ?
                     dest_reg : second_reg;

  legv8_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk       (clk),
    .wr_en     (s1_fire && do_write),
    .wr_addr   (wr_addr),
    .wr_data   (wr_value),
    .rd_en     (in_fire),
    .rd_addr_a (first_reg),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  // advance the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action <= op_t'(action);
      s1_dest   <= dest_reg;
      s1_addr_a <= first_reg;
      s1_addr_b <= rd_addr_b;
      s1_imm    <= immediate;
      s1_target <= target_line;
    end
  end

  // operands: bypass last write, then unwritten registers read as zero
  always_comb begin
    if (wb_en && wb_addr == s1_addr_a) begin
      a_val = wb_data;
    end else if (reg_valid[s1_addr_a]) begin
      a_val = ram_a;
    end else begin
      a_val = '0;
    end
    if (wb_en && wb_addr == s1_addr_b) begin
      b_val = wb_data;
    end else if (reg_valid[s1_addr_b]) begin
      b_val = ram_b;
    end else begin
      b_val = '0;
    end
  end

  always_comb begin
    imm64    = {{(XLEN-12){1'b0}}, s1_imm};
    uses_imm = (s1_action == OP_ADDI) || (s1_action == OP_ADDIS) ||
               (s1_action == OP_SUBI) || (s1_action == OP_SUBIS);
    is_sub   = (s1_action == OP_SUB)  || (s1_action == OP_SUBS) ||
               (s1_action == OP_SUBI) || (s1_action == OP_SUBIS);
    opnd     = uses_imm ? imm64 : b_val;
    bop      = is_sub ? ~opnd : opnd;
    sum      = {1'b0, a_val} + {1'b0, bop} + {{XLEN{1'b0}}, is_sub};
    arith    = sum[XLEN-1:0];
    carry    = sum[XLEN];
    ovf      = ~(a_val[XLEN-1] ^ bop[XLEN-1]) & (a_val[XLEN-1] ^ arith[XLEN-1]);
    seq_line = line + LINE_W'(1);

    line_next  = seq_line;
    do_write   = 1'b0;
    wr_addr    = s1_dest;
    wr_value   = '0;
    flags_next = flags;
    redirect   = 1'b0;

    unique case (s1_action)
      OP_ADD, OP_ADDI, OP_SUB, OP_SUBI: begin
        do_write = 1'b1;
        wr_value = arith;
      end
      OP_ADDS, OP_ADDIS, OP_SUBS, OP_SUBIS: begin
        do_write   = 1'b1;
        wr_value   = arith;
        flags_next = '{n: arith[XLEN-1], z: (arith == '0), c: carry, v: ovf};
      end
      OP_AND: begin
        do_write = 1'b1;
        wr_value = a_val & b_val;
      end
      OP_ANDS: begin
        do_write   = 1'b1;
        wr_value   = a_val & b_val;
        flags_next = '{n: wr_value[XLEN-1], z: (wr_value == '0), c: 1'b0, v: 1'b0};
      end
      OP_ORR: begin
        do_write = 1'b1;
        wr_value = a_val | b_val;
      end
      OP_EOR: begin
        do_write = 1'b1;
        wr_value = a_val ^ b_val;
      end
      OP_ANDI: begin
        do_write = 1'b1;
        wr_value = a_val & imm64;
      end
      OP_ANDIS: begin
        do_write   = 1'b1;
        wr_value   = a_val & imm64;
        flags_next = '{n: wr_value[XLEN-1], z: (wr_value == '0), c: 1'b0, v: 1'b0};
      end
      OP_ORRI: begin
        do_write = 1'b1;
        wr_value = a_val | imm64;
      end
      OP_EORI: begin
        do_write = 1'b1;
        wr_value = a_val ^ imm64;
      end
      OP_LSL: begin
        do_write = 1'b1;
        wr_value = a_val << s1_imm[5:0];
      end
      OP_LSR: begin
        do_write = 1'b1;
        wr_value = a_val >> s1_imm[5:0];
      end
      OP_B: begin
        line_next = s1_target;
        redirect  = 1'b1;
      end
      OP_BL: begin
        do_write  = 1'b1;
        wr_addr   = LINK_REG;
        wr_value  = {{(XLEN-LINE_W){1'b0}}, seq_line};
        line_next = s1_target;
        redirect  = 1'b1;
      end
      OP_BR: begin
        line_next = b_val[LINE_W-1:0];
        redirect  = 1'b1;
      end
      OP_CBZ: begin
        if (b_val == '0) begin
          line_next = s1_target;
          redirect  = 1'b1;
        end
      end
      OP_CBNZ: begin
        if (b_val != '0) begin
          line_next = s1_target;
          redirect  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // commit architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= '0;
      flags     <= '0;
      reg_valid <= '0;
      wb_en     <= 1'b0;
    end else if (s1_fire) begin
      line  <= line_next;
      flags <= flags_next;
      wb_en <= do_write;
      if (do_write) begin
        reg_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      wb_addr <= wr_addr;
      wb_data <= wr_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      next_line     <= line_next;
      wrote         <= do_write;
      written_value <= wr_value;
      out_flags     <= flags_next;
    end
  end

  assign flag_n = out_flags.n;
  assign flag_z = out_flags.z;
  assign flag_c = out_flags.c;
  assign flag_v = out_flags.v;

`ifndef SYNTHESIS
  a_fire_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("executed transaction did not reach the output register");

  a_sequential_line: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !redirect |=> line == $past(line) + LINE_W'(1))
    else $error("line counter did not advance by one");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !wrote |-> written_value == '0)
    else $error("nonzero value reported without a register write");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while execute stage is stalled");
`endif

endmodule

// File: tb/sv/legv8_exec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// legv8_exec_checker
// Watches both channels of the execute unit, predicts each result from its
// own register file, line counter and NZCV copy, and compares in order.
// ----------------------------------------------------------------------------
module legv8_exec_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [4:0]         action,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         first_reg,
  input  logic [4:0]         second_reg,
  input  logic [11:0]        immediate,
  input  logic [9:0]         target_line,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [9:0]         next_line,
  input  logic               wrote,
  input  logic signed [63:0] written_value,
  input  logic               flag_n,
  input  logic               flag_z,
  input  logic               flag_c,
  input  logic               flag_v,
  output int                 errors,
  output int                 outstanding
);
  import legv8_pkg::*;

  typedef struct packed {
    logic [LINE_W-1:0] next_line;
    logic              wrote;
    logic [XLEN-1:0]   value;
    flags_t            flags;
  } exec_result_t;

  logic [XLEN-1:0]   model_regs [NUM_REGS];
  logic [LINE_W-1:0] model_line;
  flags_t            model_flags;
  exec_result_t      pending_results [$];
  exec_result_t      predicted;
  exec_result_t      want;

  function automatic logic [XLEN-1:0] add_with_flags(logic [XLEN-1:0] a, logic [XLEN-1:0] b,
                                                      logic cin);
    logic [XLEN:0]   sum;
    logic [XLEN-1:0] ovf;
    sum = {1'b0, a} + {1'b0, b} + {{XLEN{1'b0}}, cin};
    ovf = ~(a ^ b) & (a ^ sum[XLEN-1:0]);
    model_flags = {sum[XLEN-1], sum[XLEN-1:0] == '0, sum[XLEN], ovf[XLEN-1]};
    return sum[XLEN-1:0];
  endfunction

  function automatic exec_result_t execute_insn(logic [4:0] act, logic [4:0] rd_idx,
                                                logic [4:0] rn, logic [4:0] rm,
                                                logic [11:0] imm, logic [9:0] tgt);
    logic [XLEN-1:0]   a;
    logic [XLEN-1:0]   b;
    logic [XLEN-1:0]   imm64;
    logic [XLEN-1:0]   val;
    logic [4:0]        wr_idx;
    logic [LINE_W-1:0] seq_line;
    logic [LINE_W-1:0] nxt;
    logic              wr;
    exec_result_t      res;
    a        = model_regs[rn];
    b        = model_regs[rm];
    imm64    = {{(XLEN-12){1'b0}}, imm};
    seq_line = model_line + 1'b1;
    nxt      = seq_line;
    wr       = 1'b0;
    val      = '0;
    wr_idx   = rd_idx;
    case (act)
      OP_ADD:   begin val = a + b; wr = 1'b1; end
      OP_ADDS:  begin val = add_with_flags(a, b, 1'b0); wr = 1'b1; end
      OP_ADDI:  begin val = a + imm64; wr = 1'b1; end
      OP_ADDIS: begin val = add_with_flags(a, imm64, 1'b0); wr = 1'b1; end
      OP_SUB:   begin val = a - b; wr = 1'b1; end
      OP_SUBS:  begin val = add_with_flags(a, ~b, 1'b1); wr = 1'b1; end
      OP_SUBI:  begin val = a - imm64; wr = 1'b1; end
      OP_SUBIS: begin val = add_with_flags(a, ~imm64, 1'b1); wr = 1'b1; end
      OP_AND,
      OP_ANDS:  begin val = a & b; wr = 1'b1; end
      OP_ORR:   begin val = a | b; wr = 1'b1; end
      OP_EOR:   begin val = a ^ b; wr = 1'b1; end
      OP_ANDI,
      OP_ANDIS: begin val = a & imm64; wr = 1'b1; end
      OP_ORRI:  begin val = a | imm64; wr = 1'b1; end
      OP_EORI:  begin val = a ^ imm64; wr = 1'b1; end
      OP_LSL:   begin val = a << imm[5:0]; wr = 1'b1; end
      OP_LSR:   begin val = a >> imm[5:0]; wr = 1'b1; end
      OP_B:     nxt = tgt;
      OP_BL: begin
        val    = {{(XLEN-LINE_W){1'b0}}, seq_line};
        wr     = 1'b1;
        wr_idx = LINK_REG;
        nxt    = tgt;
      end
      OP_BR:    nxt = model_regs[rd_idx][LINE_W-1:0];
      OP_CBZ:   if (model_regs[rd_idx] == '0) nxt = tgt;
      OP_CBNZ:  if (model_regs[rd_idx] != '0) nxt = tgt;
      default:  ;
    endcase
    if (act == OP_ANDS || act == OP_ANDIS) model_flags = {val[XLEN-1], val == '0, 2'b00};
    if (wr) model_regs[wr_idx] = val;
    model_line    = nxt;
    res.next_line = nxt;
    res.wrote     = wr;
    res.value     = wr ? val : '0;
    res.flags     = model_flags;
    return res;
  endfunction

  task automatic check_field(string name, logic [XLEN-1:0] exp_v, logic [XLEN-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (model_regs[i]) model_regs[i] = '0;
      model_line  = '0;
      model_flags = '0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        predicted = execute_insn(action, dest_reg, first_reg, second_reg,
                                 immediate, target_line);
        pending_results = {pending_results, predicted};
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual next_line %0d",
                   $time, next_line);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("next_line", XLEN'(want.next_line), XLEN'(next_line));
          check_field("wrote", XLEN'(want.wrote), XLEN'(wrote));
          check_field("written_value", want.value, written_value);
          check_field("flag_n", XLEN'(want.flags.n), XLEN'(flag_n));
          check_field("flag_z", XLEN'(want.flags.z), XLEN'(flag_z));
          check_field("flag_c", XLEN'(want.flags.c), XLEN'(flag_c));
          check_field("flag_v", XLEN'(want.flags.v), XLEN'(flag_v));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// File: tb/sv/tb_legv8_subset_execute_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_legv8_subset_execute_unit
// Drives directed and random instruction streams with bursty input and a
// patterned output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_legv8_subset_execute_unit;
  import legv8_pkg::*;

  localparam int          RANDOM_ITEMS   = 1823;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          TAIL_CYCLES    = 8;
  localparam int          LONG_HOLD      = 60;
  localparam logic [4:0]  UNUSED_OP      = 5'd31;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [4:0]         action;
  logic [4:0]         dest_reg;
  logic [4:0]         first_reg;
  logic [4:0]         second_reg;
  logic [11:0]        immediate;
  logic [9:0]         target_line;
  logic               out_valid;
  logic               out_ready;
  logic [9:0]         next_line;
  logic               wrote;
  logic signed [63:0] written_value;
  logic               flag_n;
  logic               flag_z;
  logic               flag_c;
  logic               flag_v;
  int                 errors;
  int                 outstanding;
  int                 stall_asked;
  int                 stall_served;

  legv8_subset_execute_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .dest_reg(dest_reg), .first_reg(first_reg),
    .second_reg(second_reg), .immediate(immediate), .target_line(target_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_line(next_line), .wrote(wrote), .written_value(written_value),
    .flag_n(flag_n), .flag_z(flag_z), .flag_c(flag_c), .flag_v(flag_v)
  );

  legv8_exec_checker u_exec_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .dest_reg(dest_reg), .first_reg(first_reg),
    .second_reg(second_reg), .immediate(immediate), .target_line(target_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_line(next_line), .wrote(wrote), .written_value(written_value),
    .flag_n(flag_n), .flag_z(flag_z), .flag_c(flag_c), .flag_v(flag_v),
    .errors(errors), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_insn(input logic [4:0] act, input logic [4:0] d, input logic [4:0] n,
                           input logic [4:0] m, input logic [11:0] imm,
                           input logic [9:0] tgt);
    @(negedge clk);
    action      <= act;
    dest_reg    <= d;
    first_reg   <= n;
    second_reg  <= m;
    immediate   <= imm;
    target_line <= tgt;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Half the picks come from a small pool so results feed the next instructions.
  function automatic logic [4:0] pick_reg();
    return $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
  endfunction

  task automatic send_random_insn();
    logic [4:0]  op;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [11:0] imm;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 70)      op = 5'($urandom_range(int'(OP_LSR), int'(OP_ADD)));
    else if (sel < 92) op = 5'($urandom_range(int'(OP_CBNZ), int'(OP_B)));
    else               op = 5'($urandom);
    rn = pick_reg();
    rm = ($urandom_range(0, 7) == 0) ? rn : pick_reg();
    case ($urandom_range(0, 7))
      0, 1:    imm = 12'($urandom_range(0, 63));
      2:       imm = $urandom_range(0, 1) ? '1 : '0;
      default: imm = 12'($urandom);
    endcase
    send_insn(op, pick_reg(), rn, rm, imm, 10'($urandom_range(0, 1023)));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Receiver: rotating ready pattern, re-drawn now and then, plus long holds on request.
  initial begin
    logic [15:0] ready_pattern;
    int          pattern_age;
    int          hold_left;
    out_ready     = 1'b0;
    stall_served  = 0;
    ready_pattern = '1;
    pattern_age   = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_served) begin
        stall_served++;
        hold_left = LONG_HOLD;
      end
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = 16'($urandom);
          2:       ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
      pattern_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready     <= ready_pattern[0];
        ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("tb_legv8_subset_execute_unit: done, errors");
    $finish;
  end

  initial begin
    int items;
    int bursts;
    int len;
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = '0;
    dest_reg    = '0;
    first_reg   = '0;
    second_reg  = '0;
    immediate   = '0;
    target_line = '0;
    stall_asked = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // x0 stays zero throughout the directed part
    send_insn(OP_ORRI,  5'd1,  5'd0,  5'd0, 12'd1,    10'd0);
    send_insn(OP_LSL,   5'd2,  5'd1,  5'd0, 12'd63,   10'd0);
    send_insn(OP_SUBI,  5'd3,  5'd2,  5'd0, 12'd1,    10'd0);
    send_insn(OP_ADDS,  5'd4,  5'd3,  5'd1, 12'd0,    10'd0);
    send_insn(OP_SUBS,  5'd5,  5'd2,  5'd1, 12'd0,    10'd0);
    send_insn(OP_ADDS,  5'd6,  5'd2,  5'd2, 12'd0,    10'd0);
    send_insn(OP_SUBIS, 5'd7,  5'd0,  5'd0, 12'd1,    10'd0);
    send_insn(OP_ADDIS, 5'd8,  5'd7,  5'd0, 12'd4095, 10'd0);
    send_insn(OP_ANDS,  5'd9,  5'd2,  5'd7, 12'd0,    10'd0);
    send_insn(OP_ANDIS, 5'd10, 5'd1,  5'd0, 12'd0,    10'd0);
    send_insn(OP_ADD,   5'd11, 5'd7,  5'd3, 12'd0,    10'd0);
    send_insn(OP_SUB,   5'd12, 5'd0,  5'd3, 12'd0,    10'd0);
    send_insn(OP_ADDI,  5'd31, 5'd31, 5'd0, 12'd4095, 10'd0);
    send_insn(OP_AND,   5'd13, 5'd7,  5'd3, 12'd0,    10'd0);
    send_insn(OP_ORR,   5'd14, 5'd1,  5'd2, 12'd0,    10'd0);
    send_insn(OP_EOR,   5'd15, 5'd7,  5'd2, 12'd0,    10'd0);
    send_insn(OP_ANDI,  5'd16, 5'd7,  5'd0, 12'd4095, 10'd0);
    send_insn(OP_EORI,  5'd17, 5'd7,  5'd0, 12'd4095, 10'd0);
    send_insn(OP_LSR,   5'd18, 5'd2,  5'd0, 12'd4095, 10'd0);
    send_insn(OP_B,     5'd0,  5'd0,  5'd0, 12'd0,    10'd1023);
    send_insn(OP_ORR,   5'd20, 5'd1,  5'd1, 12'd0,    10'd0);
    send_insn(OP_BL,    5'd5,  5'd0,  5'd0, 12'd0,    10'd1000);
    send_insn(OP_BR,    5'd7,  5'd0,  5'd0, 12'd0,    10'd0);
    send_insn(OP_CBZ,   5'd0,  5'd0,  5'd0, 12'd0,    10'd5);
    send_insn(OP_CBZ,   5'd1,  5'd0,  5'd0, 12'd0,    10'd9);
    send_insn(OP_CBNZ,  5'd1,  5'd0,  5'd0, 12'd0,    10'd700);
    send_insn(UNUSED_OP, 5'd31, 5'd31, 5'd31, 12'd4095, 10'd1023);
    wait_drained();

    items  = 0;
    bursts = 0;
    while (items < RANDOM_ITEMS) begin
      bursts++;
      if (bursts % 40 == 20) begin
        // hold the receiver off while the sender keeps offering
        send_random_insn();
        stall_asked++;
        repeat (11) send_random_insn();
        items += 12;
      end else begin
        len = $urandom_range(1, 24);
        repeat (len) send_random_insn();
        items += len;
      end
      if (bursts % 40 == 0) wait_drained();
      else if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("tb_legv8_subset_execute_unit: done, clean");
    else
      $display("tb_legv8_subset_execute_unit: done, errors");
    $finish;
  end

endmodule
